[rtl/adaptive_scale_saturating_quantizer_unit_macros.svh]
// Assertion helpers used by asq_ctrl.
`ifndef ADAPTIVE_SCALE_SATURATING_QUANTIZER_UNIT_MACROS_SVH
`define ADAPTIVE_SCALE_SATURATING_QUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ASQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asq check failed");

// Next-cycle implication.
`define ASQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asq check failed");

`endif

[rtl/asq_pkg.sv]
package asq_pkg;

   localparam int FRAME_MAX  = 64;
   localparam int ADDR_W     = 6;
   localparam int CNT_W      = 7;
   localparam int DIV_STEPS  = 35;

   typedef enum logic [1:0] {
      CSR_FRAME_LENGTH    = 2'd0,
      CSR_STEP_INVERSE    = 2'd1,
      CSR_SATURATION_BITS = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
      logic              ld_in;
      logic              ld_mem;
      logic              mul;
      logic              ld_out;
      logic              last;
      logic              ld_cand;
      logic              clr_cnt;
      logic              cmp;
      logic              div_start;
      logic              div_step;
      logic              learn;
   } cmd_type;

   typedef struct packed {
      logic             step_nz;
      logic             learned;
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] cnt_lt;
      logic [CNT_W-1:0] cnt_le;
   } sts_type;

   // Magnitude of a 16-bit two's complement sample; -32768 gives 32768.
   function automatic logic [16:0] mag17(input logic signed [15:0] s);
      logic [16:0] e;
      e = {s[15], s};
      return s[15] ? (17'd0 - e) : e;
   endfunction

   // Saturation limit 2^(b-1)-1 with b clamped to 2..16.
   function automatic logic [15:0] val_max(input logic [4:0] b);
      logic [4:0]  bc;
      logic [16:0] one;
      bc = (b < 5'd2) ? 5'd2 : ((b > 5'd16) ? 5'd16 : b);
      one = 17'd1 << (bc - 5'd1);
      return 16'(one - 17'd1);
   endfunction

endpackage

[rtl/asq_datapath.sv]
module asq_datapath
   import asq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [15:0] req_sample,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output logic signed [15:0] rsp_quantized,
   output logic               rsp_last_of_run
);

   logic [6:0]  len_ff;
   logic [23:0] step_ff;
   logic [4:0]  sat_ff;

   logic [15:0] mem [FRAME_MAX];
   logic [15:0] rd_data_ff;

   logic [15:0] samp_ff;
   logic [15:0] samp_in;
   logic [40:0] prod_ff;
   logic        neg_ff;
   logic [15:0] q_ff;
   logic        last_ff;

   logic [16:0]      cand_ff;
   logic [CNT_W-1:0] lt_ff;
   logic [CNT_W-1:0] le_ff;

   logic [34:0] sh_ff;
   logic [17:0] rem_ff;
   logic [34:0] quo_ff;
   logic [23:0] learned_ff;
   logic        learned_flag_ff;

   logic [23:0] step_sel;
   logic [16:0] rd_mag;
   logic [41:0] rounded;
   logic [21:0] p;
   logic [15:0] vm;
   logic [15:0] p_sat;
   logic [17:0] trial;
   logic [15:0] q_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 7'd64;
         step_ff <= 24'd0;
         sat_ff  <= 5'd8;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_LENGTH:    len_ff  <= csr_wdata[6:0];
            CSR_STEP_INVERSE:    step_ff <= csr_wdata;
            CSR_SATURATION_BITS: sat_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // frame buffer
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= req_sample;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   assign step_sel = (step_ff != 24'd0) ? step_ff : learned_ff;
   assign rd_mag   = mag17(rd_data_ff);
   assign vm       = val_max(sat_ff);
   assign rounded  = {1'b0, prod_ff} + 42'(1 << 19);
   assign p        = rounded[41:20];
   assign p_sat    = (p > {6'd0, vm}) ? vm : p[15:0];
   assign q_in     = neg_ff ? (16'd0 - p_sat) : p_sat;
   assign trial    = {rem_ff[16:0], sh_ff[34]};
   assign samp_in  = cmd.ld_in ? req_sample : rd_data_ff;

   // quantize path
   always_ff @(posedge clock) begin
      if (cmd.ld_in || cmd.ld_mem) begin
         samp_ff <= samp_in;
      end
      if (cmd.mul) begin
         prod_ff <= 41'(mag17(samp_ff) * step_sel);
         neg_ff  <= samp_ff[15];
      end
      if (cmd.ld_out) begin
         q_ff    <= q_in;
         last_ff <= cmd.last;
      end
   end

   // rank search and step division
   always_ff @(posedge clock) begin
      if (cmd.ld_cand) begin
         cand_ff <= rd_mag;
      end
      if (cmd.clr_cnt) begin
         lt_ff <= '0;
         le_ff <= '0;
      end else if (cmd.cmp) begin
         lt_ff <= lt_ff + CNT_W'(rd_mag < cand_ff);
         le_ff <= le_ff + CNT_W'(rd_mag <= cand_ff);
      end
      if (cmd.div_start) begin
         sh_ff  <= {vm[14:0], 20'd0};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         sh_ff <= {sh_ff[33:0], 1'b0};
         if (trial >= {1'b0, cand_ff}) begin
            rem_ff <= trial - {1'b0, cand_ff};
            quo_ff <= {quo_ff[33:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[33:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learned_ff      <= 24'd0;
         learned_flag_ff <= 1'b0;
      end else if (cmd.learn) begin
         learned_ff      <= (quo_ff[34:24] != 11'd0) ? 24'hFFFFFF : quo_ff[23:0];
         learned_flag_ff <= 1'b1;
      end
   end

   always_comb begin
      sts.step_nz = (step_ff != 24'd0);
      sts.learned = learned_flag_ff;
      sts.len     = (len_ff == 7'd0) ? 7'd1 : ((len_ff > 7'd64) ? 7'd64 : len_ff);
      sts.cnt_lt  = lt_ff;
      sts.cnt_le  = le_ff;
   end

   assign rsp_quantized   = q_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[rtl/asq_ctrl.sv]
module asq_ctrl
   import asq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   `include "adaptive_scale_saturating_quantizer_unit_macros.svh"

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_QMUL  = 12'b0000_0000_0010,
      S_QRND  = 12'b0000_0000_0100,
      S_QOUT  = 12'b0000_0000_1000,
      S_SCAND = 12'b0000_0001_0000,
      S_SCLD  = 12'b0000_0010_0000,
      S_SCAN  = 12'b0000_0100_0000,
      S_SCHK  = 12'b0000_1000_0000,
      S_DIV   = 12'b0001_0000_0000,
      S_LEARN = 12'b0010_0000_0000,
      S_EMRD  = 12'b0100_0000_0000,
      S_EMLD  = 12'b1000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [5:0]       dcnt_ff, dcnt_in;
   logic             emit_ff, emit_in;

   logic             accept;
   logic             direct;
   logic [CNT_W-1:0] fill_next;
   logic [14:0]      tenth_prod;
   logic [CNT_W-1:0] rank_k;
   logic             found;
   logic             emit_last;

   assign accept     = req_valid && !req_stall;
   assign direct     = sts.step_nz || sts.learned;
   assign fill_next  = fill_ff + 7'd1;
   // n/10 for n <= 64 via reciprocal multiply
   assign tenth_prod = {8'd0, fill_ff} * 15'd205;
   assign rank_k     = {tenth_prod[14:11], 3'b000};
   assign found      = (sts.cnt_lt <= rank_k) && (rank_k < sts.cnt_le);
   assign emit_last  = (idx_ff == fill_ff - 7'd1);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_QOUT);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      j_in     = j_ff;
      dcnt_in  = dcnt_ff;
      emit_in  = emit_ff;
      cmd      = '0;
      cmd.wr_addr = fill_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (direct) begin
                  cmd.ld_in = 1'b1;
                  state_in  = S_QMUL;
               end else begin
                  cmd.wr_en = (fill_ff < 7'(FRAME_MAX));
                  fill_in   = fill_next;
                  if (fill_next >= sts.len) begin
                     idx_in   = '0;
                     state_in = S_SCAND;
                  end
               end
            end
         end
         S_QMUL: begin
            cmd.mul  = 1'b1;
            state_in = S_QRND;
         end
         S_QRND: begin
            cmd.ld_out = 1'b1;
            cmd.last   = emit_ff ? emit_last : 1'b1;
            state_in   = S_QOUT;
         end
         S_QOUT: begin
            if (!rsp_stall) begin
               if (emit_ff && !emit_last) begin
                  idx_in   = idx_ff + 7'd1;
                  state_in = S_EMRD;
               end else begin
                  if (emit_ff) begin
                     fill_in = '0;
                  end
                  emit_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAND: begin
            cmd.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_SCLD;
         end
         S_SCLD: begin
            cmd.ld_cand = 1'b1;
            cmd.clr_cnt = 1'b1;
            j_in        = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cmd.rd_addr = j_ff[ADDR_W-1:0];
            cmd.cmp     = (j_ff != '0);
            if (j_ff == fill_ff) begin
               state_in = S_SCHK;
            end else begin
               j_in = j_ff + 7'd1;
            end
         end
         S_SCHK: begin
            if (found) begin
               cmd.div_start = 1'b1;
               dcnt_in       = '0;
               state_in      = S_DIV;
            end else begin
               idx_in   = idx_ff + 7'd1;
               state_in = S_SCAND;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (dcnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = S_LEARN;
            end else begin
               dcnt_in = dcnt_ff + 6'd1;
            end
         end
         S_LEARN: begin
            cmd.learn = 1'b1;
            idx_in    = '0;
            emit_in   = 1'b1;
            state_in  = S_EMRD;
         end
         S_EMRD: begin
            cmd.rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_EMLD;
         end
         S_EMLD: begin
            cmd.ld_mem = 1'b1;
            state_in   = S_QMUL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
         j_ff     <= '0;
         dcnt_ff  <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         j_ff     <= j_in;
         dcnt_ff  <= dcnt_in;
         emit_ff  <= emit_in;
      end
   end

   `ASQ_ASSERT_NEXT(a_out_hold, clock, reset, state_ff == S_QOUT && rsp_stall, state_ff == S_QOUT)
   `ASQ_ASSERT_NEXT(a_found_div, clock, reset, state_ff == S_SCHK && found, state_ff == S_DIV)
   `ASQ_ASSERT_NOW(a_emit_no_direct, clock, reset, emit_ff, sts.learned || state_ff == S_EMRD)
   `ASQ_ASSERT_NOW(a_fill_bound, clock, reset, state_ff == S_IDLE, fill_ff < 7'(FRAME_MAX))

endmodule

[rtl/adaptive_scale_saturating_quantizer_unit.sv]
// Adaptive-scale saturating quantizer. Each req_ transaction carries one
// signed sample (8 fraction bits); the unit multiplies its magnitude by the
// inverse step (12 fraction bits), rounds half away from zero, saturates to
// +/-(2^(saturation_bits-1)-1) and restores the sign. With a nonzero
// step_inverse, or once a step has been learned, each sample produces one
// rsp_ transaction (last_of_run set); the sample is registered, multiplied,
// rounded and saturated into the result register, and then offered, and the
// next sample is taken in the cycle after the result leaves, so the unit
// takes no new sample while one is in flight. With step_inverse zero and
// nothing learned, samples are buffered one per cycle with no results until
// the frame of n = frame_length (clamped to 1..64) samples is full. The unit
// then finds the magnitude of rank (n/10)*8 by a compare-and-count scan over
// the buffer, one buffer read per cycle, then runs a restoring divide for
// val_max*2^20 divided by that magnitude, and replays the whole frame, each
// sample read, loaded, multiplied, rounded and presented in turn, with
// last_of_run on the final one. The one-read-port frame buffer and the scan
// loop set the calibration time.
// Configuration writes are accepted every cycle (csr_ready is always high)
// and must only be issued while the unit is idle.
module adaptive_scale_saturating_quantizer_unit
   import asq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input samples
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   // quantized results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_quantized,
   output logic               rsp_last_of_run,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // no backpressure on register writes
   assign csr_ready = 1'b1;

   // sequencing: direct quantize, fill, rank scan, divide, replay
   asq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // buffer, multiplier, counters, divider, registers
   asq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_sample      (req_sample),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_quantized   (rsp_quantized),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
